@@ rtl/oss_dec_pkg.sv @@
// Shared types and constants for the open-shop schedule decoder.
// No dependencies; imported by oss_dec_ready_mem and open_shop_schedule_decoder.
`default_nettype none

package oss_dec_pkg;

    // Field widths of the stream words.
    localparam int JOB_W       = 6;
    localparam int MACH_W      = 6;
    localparam int PROC_W      = 16;
    localparam int OUT_TIME_W  = 32;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 64;
    localparam int IDX_CMP_W   = 11;

    // Write request to a ready-time store.
    typedef struct packed {
        logic en;
        logic clear;
    } oss_dec_wr_ctl_t;

endpackage

`default_nettype wire

@@ rtl/oss_dec_ready_mem.sv @@
// Ready-time store: one memory with a valid bit per entry and write forwarding.
// Depends on oss_dec_pkg for the write request type.
`default_nettype none

module oss_dec_ready_mem
    import oss_dec_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  rd_en,
    input  wire logic [ADDR_W-1:0]     rd_addr,
    input  wire oss_dec_wr_ctl_t       wr_ctl,
    input  wire logic [ADDR_W-1:0]     wr_addr,
    input  wire logic [DATA_W-1:0]     wr_data,
    output logic      [DATA_W-1:0]     rd_time
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [DEPTH-1:0]  valid_next;
    logic [DATA_W-1:0] rd_data_reg;
    logic              rd_valid_reg;
    logic              fwd_reg;
    logic [DATA_W-1:0] fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_ctl.en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // A clear clears every entry and then marks the entry written alongside it.
    always_comb
    begin
        valid_next = valid_reg;
        if (wr_ctl.en)
        begin
            if (wr_ctl.clear)
            begin
                valid_next = '0;
            end
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr] & ~(wr_ctl.en & wr_ctl.clear);
                fwd_reg      <= wr_ctl.en && (wr_addr == rd_addr);
            end
        end
    end

    assign rd_time = fwd_reg      ? fwd_data_reg :
                     rd_valid_reg ? rd_data_reg  : '0;

endmodule

`default_nettype wire

@@ rtl/open_shop_schedule_decoder.sv @@
// Open-shop schedule decoder: places each operation at the earliest time at
// which its job and machine are both free, and reports its end and the makespan.
// An accepted word is registered in the operation stage, its result in the result
// register; one word is accepted every cycle unless the output stalls.
// Reset (asynchronous, active low) clears all ready times, the makespan and
// the pipeline valid flags. Depends on oss_dec_pkg and oss_dec_ready_mem.
`default_nettype none

module open_shop_schedule_decoder
    import oss_dec_pkg::*;
#(
    parameter int MAX_JOBS     = 64,
    parameter int MAX_MACHINES = 64,
    parameter int TIME_BITS    = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Input stream. tdata: job[5:0], machine[11:6], proc_time[27:12], zeros above.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // tuser: first_op[0], marks the first operation of a new sequence.
    input  wire logic                  s_tuser,
    // Output stream. tdata: end_time[31:0], makespan[63:32].
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [OUT_DATA_W-1:0] m_tdata
);

    localparam int JOB_AW  = (MAX_JOBS > 1)     ? $clog2(MAX_JOBS)     : 1;
    localparam int MACH_AW = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;

    // Input word fields.
    logic [JOB_W-1:0]   in_job;
    logic [MACH_W-1:0]  in_mach;
    logic [PROC_W-1:0]  in_proc;
    logic [JOB_AW-1:0]  in_job_idx;
    logic [MACH_AW-1:0] in_mach_idx;
    logic               in_accept;

    assign in_job  = s_tdata[JOB_W-1:0];
    assign in_mach = s_tdata[JOB_W+MACH_W-1:JOB_W];
    assign in_proc = s_tdata[JOB_W+MACH_W+PROC_W-1:JOB_W+MACH_W];

    // Indices at or above the store depth fall onto the last entry.
    always_comb
    begin
        if (IDX_CMP_W'(in_job) >= IDX_CMP_W'(MAX_JOBS))
        begin
            in_job_idx = JOB_AW'(MAX_JOBS - 1);
        end
        else
        begin
            in_job_idx = JOB_AW'(in_job);
        end
        if (IDX_CMP_W'(in_mach) >= IDX_CMP_W'(MAX_MACHINES))
        begin
            in_mach_idx = MACH_AW'(MAX_MACHINES - 1);
        end
        else
        begin
            in_mach_idx = MACH_AW'(in_mach);
        end
    end

    // Operation stage: the word whose ready times are being read out.
    logic               s1_valid_reg;
    logic               s1_first_reg;
    logic [JOB_AW-1:0]  s1_job_reg;
    logic [MACH_AW-1:0] s1_mach_reg;
    logic [PROC_W-1:0]  s1_proc_reg;
    logic               s1_go;

    // Result stage.
    logic                  out_valid_reg;
    logic [OUT_TIME_W-1:0] out_end_reg;
    logic [OUT_TIME_W-1:0] out_span_reg;

    logic [TIME_BITS-1:0] span_reg;
    logic [TIME_BITS-1:0] span_next;
    logic [TIME_BITS-1:0] job_time;
    logic [TIME_BITS-1:0] mach_time;
    logic [TIME_BITS-1:0] start_time;
    logic [TIME_BITS:0]   sum_time;
    logic [TIME_BITS-1:0] fin_time;
    logic [TIME_BITS-1:0] span_cur;
    logic [TIME_BITS+OUT_TIME_W-1:0] fin_ext;
    logic [TIME_BITS+OUT_TIME_W-1:0] span_ext;

    oss_dec_wr_ctl_t wr_ctl;

    // The operation stage moves on whenever the result register is free or
    // being emptied. While a result waits unread, one more word still fits in
    // the operation stage, and then the input side stalls.
    assign s1_go     = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || s1_go;
    assign in_accept = s_tvalid && s_tready;

    assign wr_ctl.en    = s1_go;
    assign wr_ctl.clear = s1_first_reg;

    // Both stores read at acceptance; a write landing on the same edge is
    // forwarded inside the store, so back-to-back words on one job or machine
    // see the fresh end time.
    oss_dec_ready_mem #(
        .DEPTH  (MAX_JOBS),
        .ADDR_W (JOB_AW),
        .DATA_W (TIME_BITS)
    ) u_job_ready (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept),
        .rd_addr (in_job_idx),
        .wr_ctl  (wr_ctl),
        .wr_addr (s1_job_reg),
        .wr_data (fin_time),
        .rd_time (job_time)
    );

    oss_dec_ready_mem #(
        .DEPTH  (MAX_MACHINES),
        .ADDR_W (MACH_AW),
        .DATA_W (TIME_BITS)
    ) u_mach_ready (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept),
        .rd_addr (in_mach_idx),
        .wr_ctl  (wr_ctl),
        .wr_addr (s1_mach_reg),
        .wr_data (fin_time),
        .rd_time (mach_time)
    );

    // Start of a new sequence sees all ready times and the makespan as zero.
    always_comb
    begin
        if (s1_first_reg)
        begin
            start_time = '0;
            span_cur   = '0;
        end
        else
        begin
            start_time = (mach_time > job_time) ? mach_time : job_time;
            span_cur   = span_reg;
        end
        sum_time  = {1'b0, start_time} + (TIME_BITS+1)'(s1_proc_reg);
        fin_time  = sum_time[TIME_BITS] ? '1 : sum_time[TIME_BITS-1:0];
        span_next = (fin_time > span_cur) ? fin_time : span_cur;
        fin_ext   = {{OUT_TIME_W{1'b0}}, fin_time};
        span_ext  = {{OUT_TIME_W{1'b0}}, span_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            span_reg      <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go)
            begin
                out_valid_reg <= 1'b1;
                span_reg      <= span_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_first_reg <= s_tuser;
            s1_job_reg   <= in_job_idx;
            s1_mach_reg  <= in_mach_idx;
            s1_proc_reg  <= in_proc;
        end
        if (s1_go)
        begin
            out_end_reg  <= fin_ext[OUT_TIME_W-1:0];
            out_span_reg <= span_ext[OUT_TIME_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_span_reg, out_end_reg};

endmodule

`default_nettype wire
